@@ hdl/mlo_pkg.sv @@
package mlo_pkg;

  localparam int AngleFracBits  = 16;
  localparam int VectorFracBits = 14;
  localparam int CordicSteps    = 24;

  localparam logic signed [31:0] CordicGainQ30 = 32'sd652032874;
  localparam logic [24:0] YawReset  = 25'(45 * (1 << AngleFracBits));
  localparam logic [24:0] FullTurn  = 25'(360 * (1 << AngleFracBits));
  localparam logic signed [23:0] PitchLim = 24'(89 * (1 << AngleFracBits));

  // Register indexes
  localparam logic [1:0] RegSens = 2'd0;
  localparam logic [1:0] RegCx   = 2'd1;
  localparam logic [1:0] RegCy   = 2'd2;

  // Datapath commands
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_ANGLE,
    CMD_WRAP,
    CMD_CORDIC_START,
    CMD_CORDIC_STEP,
    CMD_MUL,
    CMD_OUT
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [4:0] step;
    logic       sel_pitch;
    logic [2:0] mul_idx;
  } ctrl_t;

  typedef struct packed {
    logic wrap_done;
  } stat_t;

  function automatic logic signed [31:0] atan_q24(input logic [4:0] i);
    logic signed [31:0] r;
    case (i)
      5'd0:  r = 32'sd754974720;
      5'd1:  r = 32'sd445687602;
      5'd2:  r = 32'sd235489089;
      5'd3:  r = 32'sd119537938;
      5'd4:  r = 32'sd60000934;
      5'd5:  r = 32'sd30029717;
      5'd6:  r = 32'sd15018523;
      5'd7:  r = 32'sd7509720;
      5'd8:  r = 32'sd3754917;
      5'd9:  r = 32'sd1877466;
      5'd10: r = 32'sd938734;
      5'd11: r = 32'sd469367;
      5'd12: r = 32'sd234684;
      5'd13: r = 32'sd117342;
      5'd14: r = 32'sd58671;
      5'd15: r = 32'sd29335;
      5'd16: r = 32'sd14668;
      5'd17: r = 32'sd7334;
      5'd18: r = 32'sd3667;
      5'd19: r = 32'sd1833;
      5'd20: r = 32'sd917;
      5'd21: r = 32'sd458;
      5'd22: r = 32'sd229;
      5'd23: r = 32'sd115;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  // Round a value with sh fractional bits to vector format, saturate
  function automatic logic signed [15:0] to_vec(input logic signed [63:0] v,
                                                input int sh);
    logic signed [63:0] r;
    logic signed [63:0] lim;
    lim = 64'sd1 <<< VectorFracBits;
    r = (v + (64'sd1 <<< (sh - 1))) >>> sh;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[15:0];
  endfunction

endpackage

@@ hdl/mlo_ctrl.sv @@
module mlo_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_fire,
  input  logic           out_busy,
  input  mlo_pkg::stat_t stat,
  output mlo_pkg::ctrl_t ctrl,
  output logic           busy
);

  typedef enum logic [2:0] {
    S_IDLE, S_ANGLE, S_WRAP, S_CSTART, S_CSTEP, S_MUL, S_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic [4:0] step_r, step_nxt;
  logic       pit_r, pit_nxt;
  logic [2:0] mul_r, mul_nxt;

  // Sequencer: load, angle update, yaw wrap, two CORDIC runs, four products, output
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    pit_nxt   = pit_r;
    mul_nxt   = mul_r;
    ctrl      = '{cmd: mlo_pkg::CMD_NONE, step: step_r, sel_pitch: pit_r,
                  mul_idx: mul_r};
    case (state_r)
      S_IDLE: if (in_fire) begin
        ctrl.cmd  = mlo_pkg::CMD_LOAD;
        state_nxt = S_ANGLE;
      end
      S_ANGLE: begin
        ctrl.cmd  = mlo_pkg::CMD_ANGLE;
        state_nxt = S_WRAP;
      end
      S_WRAP: begin
        ctrl.cmd = mlo_pkg::CMD_WRAP;
        if (stat.wrap_done) begin
          state_nxt = S_CSTART;
          pit_nxt   = 1'b0;
        end
      end
      S_CSTART: begin
        ctrl.cmd  = mlo_pkg::CMD_CORDIC_START;
        step_nxt  = '0;
        state_nxt = S_CSTEP;
      end
      S_CSTEP: begin
        ctrl.cmd = mlo_pkg::CMD_CORDIC_STEP;
        step_nxt = step_r + 5'd1;
        if (step_r == 5'(mlo_pkg::CordicSteps - 1)) begin
          if (pit_r) begin
            state_nxt = S_MUL;
            mul_nxt   = '0;
          end else begin
            pit_nxt   = 1'b1;
            state_nxt = S_CSTART;
          end
        end
      end
      S_MUL: begin
        ctrl.cmd = mlo_pkg::CMD_MUL;
        mul_nxt  = mul_r + 3'd1;
        if (mul_r == 3'd3) state_nxt = S_OUT;
      end
      S_OUT: if (!out_busy) begin
        ctrl.cmd  = mlo_pkg::CMD_OUT;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      pit_r   <= 1'b0;
      mul_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      pit_r   <= pit_nxt;
      mul_r   <= mul_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

@@ hdl/mlo_dp.sv @@
module mlo_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  mlo_pkg::ctrl_t     ctrl,
  output mlo_pkg::stat_t     stat,
  input  logic               cfg_fire,
  input  logic [1:0]         cfg_index,
  input  logic [19:0]        cfg_wdata,
  input  logic signed [15:0] in_x,
  input  logic signed [15:0] in_y,
  output logic signed [15:0] v_front_x,
  output logic signed [15:0] v_front_y,
  output logic signed [15:0] v_front_z,
  output logic signed [15:0] v_right_x,
  output logic signed [15:0] v_right_z,
  output logic signed [15:0] v_up_x,
  output logic signed [15:0] v_up_y,
  output logic signed [15:0] v_up_z,
  output logic [24:0]        v_yaw,
  output logic signed [23:0] v_pitch
);

  localparam int Up24 = 24 - mlo_pkg::AngleFracBits;
  // Q.24 degree constants; yaw in Q.24 needs 34 signed bits
  localparam logic signed [33:0] Deg90  = 34'sd1509949440;
  localparam logic signed [33:0] Deg180 = 34'sd3019898880;
  localparam logic signed [33:0] Deg360 = 34'sd6039797760;

  logic [19:0]        sens_r;
  logic signed [15:0] last_x_r, last_y_r;
  logic [24:0]        yaw_r;
  logic signed [23:0] pitch_r;
  logic signed [16:0] dx_r, dy_r;
  logic signed [37:0] ysum_r;   // yaw plus delta, wrapped by add/subtract steps
  logic [5:0]         wstep_r;
  logic signed [31:0] cx_r, cy_r, cz_r;
  logic signed [31:0] cy_c_r, sy_c_r;
  logic               neg_r;
  logic signed [63:0] prod_r [4];

  // Delta products: 17 x 21 bits
  logic signed [37:0] mdx, mdy, psum;
  assign mdx  = 38'(dx_r) * $signed({1'b0, sens_r});
  assign mdy  = 38'(dy_r) * $signed({1'b0, sens_r});
  assign psum = 38'(pitch_r) + mdy;

  // Wrap: reduce |sum| by FullTurn << k for k = 12 downto 0, repeating each k while it fits
  logic signed [37:0] wsh, wdec;
  logic               wneg;
  assign wsh  = 38'(mlo_pkg::FullTurn) <<< wstep_r[3:0];
  assign wneg = ysum_r < 0;
  assign wdec = wneg ? ysum_r + wsh : ysum_r - wsh;
  assign stat.wrap_done = (wstep_r == 6'd0) && !wneg && (ysum_r < 38'(mlo_pkg::FullTurn));

  // CORDIC angle setup: yaw to [-180,180), then a half turn into [-90,90]
  logic signed [33:0] ya, yr;
  logic signed [31:0] yin, pin;
  assign ya  = (yaw_r >= 25'(180 << mlo_pkg::AngleFracBits))
             ? ($signed(34'(yaw_r)) <<< Up24) - Deg360
             : $signed(34'(yaw_r)) <<< Up24;
  assign yr  = (ya > Deg90) ? ya - Deg180 : (ya < -Deg90) ? ya + Deg180 : ya;
  assign yin = yr[31:0];
  assign pin = 32'(pitch_r) <<< Up24;

  logic signed [31:0] xs, ys, at;
  assign xs = cx_r >>> ctrl.step;
  assign ys = cy_r >>> ctrl.step;
  assign at = mlo_pkg::atan_q24(ctrl.step);

  // Product operands
  logic signed [31:0] ma, mb;
  always_comb begin
    case (ctrl.mul_idx)
      3'd0: begin ma = cy_c_r; mb = cx_r; end
      3'd1: begin ma = sy_c_r; mb = cx_r; end
      3'd2: begin ma = cy_c_r; mb = cy_r; end
      3'd3: begin ma = sy_c_r; mb = cy_r; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r   <= 20'd6554;
      last_x_r <= 16'sd640;
      last_y_r <= 16'sd360;
      yaw_r    <= mlo_pkg::YawReset;
      pitch_r  <= '0;
    end else begin
      if (cfg_fire) begin
        case (cfg_index)
          mlo_pkg::RegSens: sens_r <= cfg_wdata;
          mlo_pkg::RegCx:   last_x_r <= {1'b0, cfg_wdata[14:0]};
          mlo_pkg::RegCy:   last_y_r <= {1'b0, cfg_wdata[14:0]};
          default: ;
        endcase
      end
      case (ctrl.cmd)
        mlo_pkg::CMD_LOAD: begin
          dx_r     <= 17'(in_x) - 17'(last_x_r);
          dy_r     <= 17'(last_y_r) - 17'(in_y);
          last_x_r <= in_x;
          last_y_r <= in_y;
        end
        mlo_pkg::CMD_ANGLE: begin
          ysum_r  <= 38'(yaw_r) + mdx;
          wstep_r <= 6'd12;
          if (psum > 38'(mlo_pkg::PitchLim)) pitch_r <= mlo_pkg::PitchLim;
          else if (psum < -38'(mlo_pkg::PitchLim)) pitch_r <= -mlo_pkg::PitchLim;
          else pitch_r <= psum[23:0];
        end
        mlo_pkg::CMD_WRAP: begin
          if (stat.wrap_done) yaw_r <= ysum_r[24:0];
          else if (wneg || ysum_r >= wsh) ysum_r <= wdec;
          else wstep_r <= wstep_r - 6'd1;
        end
        default: ;
      endcase
    end
  end

  // CORDIC, product and output registers
  always_ff @(posedge clk) begin
    case (ctrl.cmd)
      mlo_pkg::CMD_CORDIC_START: begin
        cx_r <= mlo_pkg::CordicGainQ30;
        cy_r <= '0;
        cz_r <= ctrl.sel_pitch ? pin : yin;
        if (!ctrl.sel_pitch) neg_r <= (ya > Deg90) || (ya < -Deg90);
        else begin
          cy_c_r <= neg_r ? -cx_r : cx_r;
          sy_c_r <= neg_r ? -cy_r : cy_r;
        end
      end
      mlo_pkg::CMD_CORDIC_STEP: begin
        if (cz_r >= 0) begin
          cx_r <= cx_r - ys; cy_r <= cy_r + xs; cz_r <= cz_r - at;
        end else begin
          cx_r <= cx_r + ys; cy_r <= cy_r - xs; cz_r <= cz_r + at;
        end
      end
      mlo_pkg::CMD_MUL: prod_r[ctrl.mul_idx[1:0]] <= 64'(ma) * 64'(mb);
      mlo_pkg::CMD_OUT: begin
        v_front_x <= mlo_pkg::to_vec(prod_r[0], 60 - mlo_pkg::VectorFracBits);
        v_front_y <= mlo_pkg::to_vec(64'(cy_r), 30 - mlo_pkg::VectorFracBits);
        v_front_z <= mlo_pkg::to_vec(prod_r[1], 60 - mlo_pkg::VectorFracBits);
        v_right_x <= mlo_pkg::to_vec(-64'(sy_c_r), 30 - mlo_pkg::VectorFracBits);
        v_right_z <= mlo_pkg::to_vec(64'(cy_c_r), 30 - mlo_pkg::VectorFracBits);
        v_up_x    <= mlo_pkg::to_vec(-prod_r[2], 60 - mlo_pkg::VectorFracBits);
        v_up_y    <= mlo_pkg::to_vec(64'(cx_r), 30 - mlo_pkg::VectorFracBits);
        v_up_z    <= mlo_pkg::to_vec(-prod_r[3], 60 - mlo_pkg::VectorFracBits);
        v_yaw     <= yaw_r;
        v_pitch   <= pitch_r;
      end
      default: ;
    endcase
  end

endmodule

@@ hdl/mouse_look_orientation_top.sv @@
// Per word: load and angle update, yaw wrap reduction, two 24-step CORDIC
// runs on one shared rotator with a setup state each, four products and the
// output load. A new word is accepted only after the last one is through;
// a result word left waiting holds the output load and with it the next accept.
// Synchronous active-low reset restores register defaults; config taken when idle.
module mouse_look_orientation_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_cursor_x,
  input  logic signed [15:0] in_cursor_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_front_x,
  output logic signed [15:0] out_front_y,
  output logic signed [15:0] out_front_z,
  output logic signed [15:0] out_right_x,
  output logic signed [15:0] out_right_z,
  output logic signed [15:0] out_up_x,
  output logic signed [15:0] out_up_y,
  output logic signed [15:0] out_up_z,
  output logic [24:0]        out_yaw_angle,
  output logic signed [23:0] out_pitch_angle,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [19:0]        cfg_data
);

  mlo_pkg::ctrl_t ctrl;
  mlo_pkg::stat_t stat;
  logic           busy, in_fire, cfg_fire, out_valid_r;

  // Config writes go first when both wait on an idle block
  assign in_ready  = !busy && !cfg_valid;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = !busy;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_valid = out_valid_r;

  mlo_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_busy(out_valid_r && !out_ready),
    .stat, .ctrl, .busy
  );

  mlo_dp u_dp (
    .clk, .rst_n, .ctrl, .stat,
    .cfg_fire, .cfg_index, .cfg_wdata(cfg_data),
    .in_x(in_cursor_x), .in_y(in_cursor_y),
    .v_front_x(out_front_x), .v_front_y(out_front_y), .v_front_z(out_front_z),
    .v_right_x(out_right_x), .v_right_z(out_right_z),
    .v_up_x(out_up_x), .v_up_y(out_up_y), .v_up_z(out_up_z),
    .v_yaw(out_yaw_angle), .v_pitch(out_pitch_angle)
  );

  // Output word register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (ctrl.cmd == mlo_pkg::CMD_OUT) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pitch_angle <= mlo_pkg::PitchLim &&
                   out_pitch_angle >= -mlo_pkg::PitchLim))
    else $error("pitch out of range");
  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_yaw_angle < mlo_pkg::FullTurn)
    else $error("yaw out of range");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> busy)
    else $error("accept did not start work");

endmodule

@@ tb/sv/mouse_look_orientation_top_tb.sv @@
module mouse_look_orientation_top_tb;

  localparam logic [1:0] RegUnused = 2'd3;
  localparam int NumVec = 8;
  localparam int DrainCycles = 100;
  localparam longint Deg24 = 64'sd16777216;
  localparam longint YawStartDeg = 45;

  typedef struct {
    logic signed [15:0] vec[NumVec];
    logic [24:0]        yaw;
    logic signed [23:0] pitch;
  } orient_t;

  // Camera orientation predictor plus queue of pending orientations
  class orient_board;
    orient_t want_q[$];
    int      errors;
    longint  sens, cx, cy, last_x, last_y, yaw_acc, pitch_acc;
    longint  atan_tab[mlo_pkg::CordicSteps];

    function new();
      atan_tab = '{754974720, 445687602, 235489089, 119537938, 60000934, 30029717,
                   15018523, 7509720, 3754917, 1877466, 938734, 469367,
                   234684, 117342, 58671, 29335, 14668, 7334,
                   3667, 1833, 917, 458, 229, 115};
      errors = 0;
      sens = 6554;
      cx = 640;
      cy = 360;
      last_x = cx;
      last_y = cy;
      yaw_acc = YawStartDeg << mlo_pkg::AngleFracBits;
      pitch_acc = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [19:0] data);
      case (idx)
        mlo_pkg::RegSens: sens = data;
        mlo_pkg::RegCx: begin
          cx = data[14:0];
          last_x = cx;
        end
        mlo_pkg::RegCy: begin
          cy = data[14:0];
          last_y = cy;
        end
        default: ;
      endcase
    endfunction

    // Rotation-mode CORDIC in degrees, Q.24 in, Q.30 out
    function void sin_cos(longint ang, output longint c, output longint s);
      longint x, y, z, xs, ys;
      x = mlo_pkg::CordicGainQ30;
      y = 0;
      z = ang;
      for (int i = 0; i < mlo_pkg::CordicSteps; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= atan_tab[i];
        end else begin
          x += ys; y -= xs; z += atan_tab[i];
        end
      end
      c = x;
      s = y;
    endfunction

    function logic signed [15:0] round_vec(longint v, int sh);
      longint r, lim;
      lim = longint'(1) << mlo_pkg::VectorFracBits;
      r = (v + (longint'(1) << (sh - 1))) >>> sh;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r[15:0];
    endfunction

    function void note_input(logic signed [15:0] px, logic signed [15:0] py);
      longint full, plim, ya, cyw, syw, cpt, spt;
      orient_t o;
      full = longint'(mlo_pkg::FullTurn);
      plim = longint'(mlo_pkg::PitchLim);
      yaw_acc = (yaw_acc + (longint'(px) - last_x) * sens) % full;
      if (yaw_acc < 0) yaw_acc += full;
      pitch_acc += (last_y - longint'(py)) * sens;
      if (pitch_acc > plim) pitch_acc = plim;
      if (pitch_acc < -plim) pitch_acc = -plim;
      last_x = px;
      last_y = py;
      // reduce yaw to [-90,90] by a half turn
      ya = yaw_acc <<< (24 - mlo_pkg::AngleFracBits);
      if (ya >= 180 * Deg24) ya -= 360 * Deg24;
      if (ya > 90 * Deg24) begin
        sin_cos(ya - 180 * Deg24, cyw, syw);
        cyw = -cyw; syw = -syw;
      end else if (ya < -90 * Deg24) begin
        sin_cos(ya + 180 * Deg24, cyw, syw);
        cyw = -cyw; syw = -syw;
      end else begin
        sin_cos(ya, cyw, syw);
      end
      sin_cos(pitch_acc <<< (24 - mlo_pkg::AngleFracBits), cpt, spt);
      o.vec[0] = round_vec(cyw * cpt, 60 - mlo_pkg::VectorFracBits);
      o.vec[1] = round_vec(spt, 30 - mlo_pkg::VectorFracBits);
      o.vec[2] = round_vec(syw * cpt, 60 - mlo_pkg::VectorFracBits);
      o.vec[3] = round_vec(-syw, 30 - mlo_pkg::VectorFracBits);
      o.vec[4] = round_vec(cyw, 30 - mlo_pkg::VectorFracBits);
      o.vec[5] = round_vec(-(cyw * spt), 60 - mlo_pkg::VectorFracBits);
      o.vec[6] = round_vec(cpt, 30 - mlo_pkg::VectorFracBits);
      o.vec[7] = round_vec(-(syw * spt), 60 - mlo_pkg::VectorFracBits);
      o.yaw = yaw_acc[24:0];
      o.pitch = pitch_acc[23:0];
      want_q.push_back(o);
    endfunction

    function void check_result(orient_t got);
      string names[NumVec];
      orient_t w;
      names = '{"front_x", "front_y", "front_z", "right_x", "right_z",
                "up_x", "up_y", "up_z"};
      if (want_q.size() == 0) begin
        $error("unexpected result word");
        errors++;
        return;
      end
      w = want_q.pop_front();
      for (int k = 0; k < NumVec; k++)
        if (got.vec[k] !== w.vec[k]) begin
          $error("%s: expected %0d, got %0d", names[k], w.vec[k], got.vec[k]);
          errors++;
        end
      if (got.yaw !== w.yaw) begin
        $error("yaw_angle: expected %0d, got %0d", w.yaw, got.yaw);
        errors++;
      end
      if (got.pitch !== w.pitch) begin
        $error("pitch_angle: expected %0d, got %0d", w.pitch, got.pitch);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  logic signed [15:0] in_cursor_x, in_cursor_y;
  logic signed [15:0] out_front_x, out_front_y, out_front_z, out_right_x, out_right_z;
  logic signed [15:0] out_up_x, out_up_y, out_up_z;
  logic [24:0] out_yaw_angle;
  logic signed [23:0] out_pitch_angle;
  logic [1:0] cfg_index;
  logic [19:0] cfg_data;

  orient_board board = new();
  bit hold_req = 0;
  bit calm = 0;
  logic signed [15:0] cur_x = 16'sd640;
  logic signed [15:0] cur_y = 16'sd360;

  mouse_look_orientation_top DUT (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("Regression FAIL");
    $finish;
  end

  // Result side: ready pattern
  initial begin
    int hold;
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_ready <= 0;
        hold = 0;
        while (hold < 400) begin
          @(posedge clk);
          hold++;
        end
      end
      out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 33);
    end
  end

  // Result side: capture and compare
  initial begin
    orient_t got;
    forever begin
      @(negedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.vec = '{out_front_x, out_front_y, out_front_z, out_right_x, out_right_z,
                    out_up_x, out_up_y, out_up_z};
        got.yaw = out_yaw_angle;
        got.pitch = out_pitch_angle;
        board.check_result(got);
      end
    end
  end

  task automatic wait_idle();
    while (board.want_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [19:0] data);
    bit ok;
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    board.write_reg(idx, data);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // Offer one cursor word, then, unless calm, sometimes drop in_valid for a random gap
  task automatic send_pos(logic signed [15:0] px, logic signed [15:0] py);
    bit ok;
    in_valid <= 1;
    in_cursor_x <= px;
    in_cursor_y <= py;
    do begin
      @(negedge clk);
      ok = in_ready;
      @(posedge clk);
    end while (!ok);
    board.note_input(px, py);
    cur_x = px;
    cur_y = py;
    if (!calm && $urandom_range(0, 99) < 33) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_move(int span);
    int jx, jy;
    jx = $urandom_range(0, 2 * span) - span;
    jy = $urandom_range(0, 2 * span) - span;
    send_pos(16'(cur_x + jx), 16'(cur_y + jy));
  endtask

  initial begin
    logic [19:0] sens_pick[5];
    sens_pick = '{20'd0, 20'hFFFFF, 20'd6554, 20'd1, 20'd65536};
    rst_n = 0;
    in_valid = 0;
    in_cursor_x = 0;
    in_cursor_y = 0;
    cfg_valid = 0;
    cfg_index = mlo_pkg::RegSens;
    cfg_data = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset state, extreme positions, pitch clamps
    send_pos(16'sd640, 16'sd360);
    send_pos(16'sd32767, -16'sd32768);
    send_pos(-16'sd32768, 16'sd32767);
    send_pos(16'sd0, 16'sd0);
    send_pos(16'sd0, -16'sd32768);
    send_pos(-16'sd1, 16'sd32767);
    in_valid <= 0;
    wait_idle();
    // zero sensitivity: angles frozen, position tracked
    write_reg(mlo_pkg::RegSens, 20'd0);
    send_pos(16'sd100, -16'sd200);
    send_pos(-16'sd30000, 16'sd30000);
    in_valid <= 0;
    wait_idle();
    // full-scale sensitivity with large motion
    write_reg(mlo_pkg::RegSens, 20'hFFFFF);
    send_pos(16'sd32767, 16'sd32767);
    send_pos(-16'sd32768, -16'sd32768);
    send_pos(-16'sd32767, -16'sd32760);
    in_valid <= 0;
    wait_idle();
    // center writes restart the reference; unknown index is dropped
    write_reg(mlo_pkg::RegCx, 20'hFFFFF);
    write_reg(mlo_pkg::RegCy, 20'd0);
    write_reg(RegUnused, 20'hABCDE);
    send_pos(16'sd32767, 16'sd0);
    send_pos(16'sd32766, 16'sd1);
    in_valid <= 0;
    wait_idle();
    write_reg(mlo_pkg::RegCx, 20'd0);
    write_reg(mlo_pkg::RegCy, 20'h07FFF);
    write_reg(mlo_pkg::RegSens, 20'd6554);
    send_pos(16'sd0, 16'sd32767);
    send_pos(16'sd5, 16'sd32760);

    // random phases: mostly small motions, some full-range jumps
    for (int ph = 0; ph < 6; ph++) begin
      in_valid <= 0;
      wait_idle();
      write_reg(mlo_pkg::RegSens,
                ph < 5 ? sens_pick[ph] : 20'($urandom_range(0, 20'hFFFFF)));
      if (ph % 2 == 1) write_reg(mlo_pkg::RegCx, 20'($urandom()));
      if (ph % 2 == 0) write_reg(mlo_pkg::RegCy, 20'($urandom()));
      if (ph == 3) write_reg(RegUnused, 20'($urandom()));
      calm = (ph == 2);
      for (int n = 0; n < 245; n++) begin
        if (ph == 1 && n == 50) hold_req = 1;
        if (ph == 4 && n == 100) begin
          in_valid <= 0;
          @(posedge clk);
          while (board.want_q.size() != 0) @(posedge clk);
        end
        if ($urandom_range(0, 99) < 75)
          send_move(ph == 3 ? 2000 : 40);
        else
          send_pos(16'($urandom()), 16'($urandom()));
      end
    end
    in_valid <= 0;
    calm = 0;

    while (board.want_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (board.errors == 0 && board.want_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
